[src/wss_pkg.sv]
package wss_pkg;

    localparam int TEMP_W      = 12;
    localparam int SUM_OUT_W   = 16;
    localparam int VAR_OUT_W   = 29;
    localparam int SLOPE_OUT_W = 23;
    localparam int LIMIT_W     = 30;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 30'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MUL_NSYY,
        S_MUL_SYSQ,
        S_MUL_CSY,
        S_MUL_NP,
        S_FIN,
        S_DONE
    } t_state;

endpackage

[src/wss_if.sv]
interface wss_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [wss_pkg::TEMP_W-1:0]  temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

interface wss_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    window_full;
    logic                                    steady;
    logic signed [wss_pkg::SUM_OUT_W-1:0]    window_sum;
    logic        [wss_pkg::VAR_OUT_W-1:0]    scaled_variance;
    logic signed [wss_pkg::SLOPE_OUT_W-1:0]  slope_numerator;
    logic signed [wss_pkg::TEMP_W-1:0]       min_sample;
    logic signed [wss_pkg::TEMP_W-1:0]       max_sample;

    modport source (output valid, output window_full, output steady, output window_sum,
                    output scaled_variance, output slope_numerator, output min_sample,
                    output max_sample, input ready);
    modport sink   (input valid, input window_full, input steady, input window_sum,
                    input scaled_variance, input slope_numerator, input min_sample,
                    input max_sample, output ready);
endinterface

[src/window_stats_steady_state.sv]
// an input transfer starts the ring walk, a drain, the multiplier states, a final step and
// the output load (straight to the load while the ring is still filling); no new sample is
// taken until loaded; the ring read port walks one sample per cycle and the shared multiplier
// then does four final products in turn; a result waits in the output register while the
// next sample is taken; reset (synchronous, active low) clears the write slot, the full flag,
// the sequencer and output valid and sets variance_limit to 65536; ring stays until written
module window_stats_steady_state #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wss_in_if.sink                             i_in,
    wss_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [wss_pkg::LIMIT_W-1:0]        i_cfg_wdata
);

    localparam int IDX_W   = $clog2(WINDOW_LEN);
    localparam int SUM_W   = wss_pkg::TEMP_W + IDX_W;
    localparam int PS_W    = wss_pkg::TEMP_W + 2 * IDX_W;
    localparam int MUL_W   = 24 + IDX_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int VAR_W   = 24 + 2 * IDX_W;
    localparam int SLOPE_W = 14 + 3 * IDX_W;
    localparam int SUMX_W  = (SUM_W > wss_pkg::SUM_OUT_W) ? SUM_W : wss_pkg::SUM_OUT_W;
    localparam int VARX_W  = (VAR_W > wss_pkg::LIMIT_W) ? VAR_W : wss_pkg::LIMIT_W;
    localparam int SLX_W   = (SLOPE_W > wss_pkg::SLOPE_OUT_W) ? SLOPE_W : wss_pkg::SLOPE_OUT_W;
    localparam int K_C     = WINDOW_LEN * (WINDOW_LEN + 1) / 2;

    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(WINDOW_LEN - 1);
    localparam logic signed [MUL_W-1:0] MUL_N    = MUL_W'(WINDOW_LEN);
    localparam logic signed [MUL_W-1:0] MUL_C    = MUL_W'(K_C);

    wss_pkg::t_state r_state, n_state;

    logic [wss_pkg::LIMIT_W-1:0] r_limit;
    logic [IDX_W-1:0]            r_wslot, n_wslot;
    logic                        r_full, n_full;
    logic                        r_res_full;
    logic [IDX_W-1:0]            r_rd_addr;
    logic [IDX_W-1:0]            r_cnt;
    logic                        r_d_vld, r_d_first, r_p_vld;

    logic signed [SUM_W-1:0]     r_sy;
    logic signed [MUL_W-1:0]     r_syy;
    logic signed [PS_W-1:0]      r_ps;
    logic signed [wss_pkg::TEMP_W-1:0] r_min, r_max;
    logic signed [VAR_W-1:0]     r_var;
    logic signed [SLOPE_W-1:0]   r_slope;

    logic                        r_out_vld;
    logic                        r_out_full, r_out_steady;
    logic signed [wss_pkg::SUM_OUT_W-1:0]   r_out_sum;
    logic        [wss_pkg::VAR_OUT_W-1:0]   r_out_var;
    logic signed [wss_pkg::SLOPE_OUT_W-1:0] r_out_slope;
    logic signed [wss_pkg::TEMP_W-1:0]      r_out_min, r_out_max;

    logic w_accept, w_in_ready, w_rd_en, w_out_load;
    logic signed [wss_pkg::TEMP_W-1:0] w_rd_data;
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [SUMX_W-1:0] w_sum_ext;
    logic [SUMX_W-wss_pkg::SUM_OUT_W:0] w_sum_hi;
    logic                     w_sum_ok;
    logic signed [wss_pkg::SUM_OUT_W-1:0] w_sum_sat;
    logic [VARX_W-1:0]        w_var_u;
    logic                     w_var_ovf, w_steady;
    logic [wss_pkg::VAR_OUT_W-1:0] w_var_sat;
    logic signed [SLX_W-1:0]  w_sl_ext;
    logic [SLX_W-wss_pkg::SLOPE_OUT_W:0] w_sl_hi;
    logic                     w_sl_ok;
    logic signed [wss_pkg::SLOPE_OUT_W-1:0] w_sl_sat;

    assign w_accept    = i_in.valid & w_in_ready;
    assign i_in.ready  = w_in_ready;

    // slot and fill flag after this sample is stored
    assign n_wslot = (r_wslot == LAST_IDX) ? '0 : r_wslot + 1'b1;
    assign n_full  = r_full | (r_wslot == LAST_IDX);

    wss_ring #(
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wslot),
        .i_wdata (i_in.temperature),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_data)
    );

    wss_mul #(
        .W (MUL_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        case (r_state)
            wss_pkg::S_MUL_NSYY: begin
                w_mul_a = MUL_N;
                w_mul_b = r_syy;
            end
            wss_pkg::S_MUL_SYSQ: begin
                w_mul_a = MUL_W'(r_sy);
                w_mul_b = MUL_W'(r_sy);
            end
            wss_pkg::S_MUL_CSY: begin
                w_mul_a = MUL_C;
                w_mul_b = MUL_W'(r_sy);
            end
            wss_pkg::S_MUL_NP: begin
                w_mul_a = MUL_N;
                w_mul_b = MUL_W'(r_ps);
            end
            default: begin
                w_mul_a = MUL_W'(w_rd_data);
                w_mul_b = MUL_W'(w_rd_data);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            wss_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = n_full ? wss_pkg::S_SCAN : wss_pkg::S_DONE;
                end
            end
            wss_pkg::S_SCAN: begin
                w_rd_en = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = wss_pkg::S_DRAIN;
                end
            end
            wss_pkg::S_DRAIN: begin
                if (!r_d_vld && !r_p_vld) begin
                    n_state = wss_pkg::S_MUL_NSYY;
                end
            end
            wss_pkg::S_MUL_NSYY: n_state = wss_pkg::S_MUL_SYSQ;
            wss_pkg::S_MUL_SYSQ: n_state = wss_pkg::S_MUL_CSY;
            wss_pkg::S_MUL_CSY:  n_state = wss_pkg::S_MUL_NP;
            wss_pkg::S_MUL_NP:   n_state = wss_pkg::S_FIN;
            wss_pkg::S_FIN:      n_state = wss_pkg::S_DONE;
            wss_pkg::S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = wss_pkg::S_IDLE;
                end
            end
            default: n_state = wss_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= wss_pkg::LIMIT_RST;
            r_wslot   <= '0;
            r_full    <= 1'b0;
            r_d_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_wslot <= n_wslot;
                r_full  <= n_full;
            end
            r_d_vld <= w_rd_en;
            r_p_vld <= r_d_vld;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // walk and accumulate
    always_ff @(posedge i_clk) begin
        r_d_first <= (r_cnt == '0);
        if (w_accept) begin
            r_res_full <= n_full;
            r_rd_addr  <= n_wslot;  // oldest sample once the ring is full
            r_cnt      <= '0;
            r_sy       <= '0;
            r_syy      <= '0;
            r_ps       <= '0;
        end
        if (w_rd_en) begin
            r_rd_addr <= (r_rd_addr == LAST_IDX) ? '0 : r_rd_addr + 1'b1;
            r_cnt     <= r_cnt + 1'b1;
        end
        if (r_d_vld) begin
            r_sy <= r_sy + SUM_W'(w_rd_data);
            if (r_d_first || w_rd_data < r_min) begin
                r_min <= w_rd_data;
            end
            if (r_d_first || w_rd_data > r_max) begin
                r_max <= w_rd_data;
            end
        end
        // sum of running sums gives N*sum(y) - sum(x*y)
        if (r_p_vld) begin
            r_syy <= r_syy + w_prod[MUL_W-1:0];
            r_ps  <= r_ps + PS_W'(r_sy);
        end
        case (r_state)
            wss_pkg::S_MUL_SYSQ: r_var   <= w_prod[VAR_W-1:0];
            wss_pkg::S_MUL_CSY:  r_var   <= r_var - w_prod[VAR_W-1:0];
            wss_pkg::S_MUL_NP:   r_slope <= w_prod[SLOPE_W-1:0];
            wss_pkg::S_FIN:      r_slope <= r_slope - w_prod[SLOPE_W-1:0];
            default: ;
        endcase
    end

    // saturation and threshold
    assign w_sum_ext = SUMX_W'(r_sy);
    assign w_sum_hi  = w_sum_ext[SUMX_W-1:wss_pkg::SUM_OUT_W-1];
    assign w_sum_ok  = (&w_sum_hi) | ~(|w_sum_hi);
    assign w_sum_sat = w_sum_ok ? w_sum_ext[wss_pkg::SUM_OUT_W-1:0] :
                       {w_sum_ext[SUMX_W-1], {(wss_pkg::SUM_OUT_W-1){~w_sum_ext[SUMX_W-1]}}};

    assign w_var_u   = VARX_W'($unsigned(r_var));
    assign w_steady  = w_var_u < VARX_W'(r_limit);
    assign w_var_ovf = |w_var_u[VARX_W-1:wss_pkg::VAR_OUT_W];
    assign w_var_sat = w_var_ovf ? '1 : w_var_u[wss_pkg::VAR_OUT_W-1:0];

    assign w_sl_ext = SLX_W'(r_slope);
    assign w_sl_hi  = w_sl_ext[SLX_W-1:wss_pkg::SLOPE_OUT_W-1];
    assign w_sl_ok  = (&w_sl_hi) | ~(|w_sl_hi);
    assign w_sl_sat = w_sl_ok ? w_sl_ext[wss_pkg::SLOPE_OUT_W-1:0] :
                      {w_sl_ext[SLX_W-1], {(wss_pkg::SLOPE_OUT_W-1){~w_sl_ext[SLX_W-1]}}};

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_res_full) begin
                r_out_full   <= 1'b1;
                r_out_steady <= w_steady;
                r_out_sum    <= w_sum_sat;
                r_out_var    <= w_var_sat;
                r_out_slope  <= w_sl_sat;
                r_out_min    <= r_min;
                r_out_max    <= r_max;
            end else begin
                r_out_full   <= 1'b0;
                r_out_steady <= 1'b0;
                r_out_sum    <= '0;
                r_out_var    <= '0;
                r_out_slope  <= '0;
                r_out_min    <= '0;
                r_out_max    <= '0;
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.window_full     = r_out_full;
    assign o_out.steady          = r_out_steady;
    assign o_out.window_sum      = r_out_sum;
    assign o_out.scaled_variance = r_out_var;
    assign o_out.slope_numerator = r_out_slope;
    assign o_out.min_sample      = r_out_min;
    assign o_out.max_sample      = r_out_max;

endmodule

[src/wss_ring.sv]
module wss_ring #(
    parameter int DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(DEPTH)-1:0]           i_waddr,
    input  logic signed [wss_pkg::TEMP_W-1:0]  i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(DEPTH)-1:0]           i_raddr,
    output logic signed [wss_pkg::TEMP_W-1:0]  o_rdata
);

    logic signed [wss_pkg::TEMP_W-1:0] r_mem [DEPTH];
    logic signed [wss_pkg::TEMP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/wss_mul.sv]
module wss_mul #(
    parameter int W = 28
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_prod
);

    logic signed [2*W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
